>>> src/fcx_pkg.sv
`timescale 1ns / 1ps
// Shared types, field widths and codes for the queue with cursor extraction.
package fcx_pkg;

    localparam int WORD_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REWIND  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ADVANCE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_EXTRACT = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOCUR = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] data;
    } t_cmd;

    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic                word_valid;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                cursor_valid;
    } t_rsp;

    typedef struct packed {
        logic latch;
        logic issue;
        logic load;
        logic sh_rd;
        logic sh_wr;
        logic fin;
    } t_ctl;

    typedef struct packed {
        logic need_word;
        logic is_extract;
        logic more;
    } t_sts;

endpackage

>>> src/fcx_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module fcx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/fcx_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences one queue transaction at a time.
module fcx_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  fcx_pkg::t_sts i_sts,
    output logic          o_busy,
    output fcx_pkg::t_ctl o_cmd
);
    import fcx_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_SH_RD = 3'd3;
    localparam logic [2:0] S_SH_WR = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.latch = i_start;
                if (i_start) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                n_state = i_sts.need_word ? S_LOAD : S_FIN;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state = i_sts.is_extract ? S_SH_RD : S_FIN;
            end
            S_SH_RD: begin
                o_cmd.sh_rd = i_sts.more;
                n_state = i_sts.more ? S_SH_WR : S_FIN;
            end
            S_SH_WR: begin
                o_cmd.sh_wr = 1'b1;
                n_state = S_SH_RD;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted transaction did not raise busy");

    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |=> !o_busy)
        else $error("controller did not return to idle after finishing");

    a_load_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> $past(o_cmd.issue))
        else $error("word load without a preceding read issue");

endmodule

>>> src/fcx_dpath.sv
`timescale 1ns / 1ps
// Datapath with the entry store, queue pointers, cursor and result register.
module fcx_dpath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fcx_pkg::t_cmd i_cmd,
    input  fcx_pkg::t_ctl i_ctl,
    output fcx_pkg::t_sts o_sts,
    output logic          o_done,
    output fcx_pkg::t_rsp o_rsp
);
    import fcx_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(DEPTH);

    logic [MODE_W-1:0]     r_mode;
    logic [DATA_WIDTH-1:0] r_data;
    logic [PTR_W-1:0]      r_head;
    logic [CNT_W-1:0]      r_fill;
    logic [PTR_W-1:0]      r_cur;
    logic                  r_cur_on;
    logic [PTR_W-1:0]      r_idx;
    logic [DATA_WIDTH-1:0] r_word;
    logic                  r_done;
    t_rsp                  r_rsp;

    logic [PTR_W-1:0]      n_head;
    logic [CNT_W-1:0]      n_fill;
    logic [PTR_W-1:0]      n_cur;
    logic                  n_cur_on;

    logic                  w_empty;
    logic                  w_full;
    logic                  w_cur_ok;
    logic [STATUS_W-1:0]   w_status;
    logic                  w_need_word;
    logic                  w_more;
    logic [PTR_W-1:0]      w_idx_nx;
    logic [PTR_W-1:0]      w_rpos;
    logic                  w_re;
    logic                  w_we;
    logic [PTR_W-1:0]      w_raddr;
    logic [PTR_W-1:0]      w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [DATA_WIDTH-1:0] w_rdata;

    // Logical position relative to the oldest entry mapped onto the circular store.
    function automatic logic [PTR_W-1:0] f_phys(input logic [PTR_W-1:0] base,
                                                input logic [PTR_W-1:0] pos);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, pos};
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[PTR_W-1:0];
    endfunction

    assign w_empty  = (r_fill == '0);
    assign w_full   = (r_fill == FULL_CNT);
    assign w_cur_ok = r_cur_on && (CNT_W'(r_cur) < r_fill);
    assign w_idx_nx = r_idx + PTR_W'(1);
    assign w_more   = (CNT_W'(r_idx) + CNT_W'(1)) < r_fill;

    always_comb begin
        w_status = ST_OK;
        case (r_mode)
            MODE_PUSH: begin
                if (w_full) w_status = ST_FULL;
            end
            MODE_POP, MODE_REWIND: begin
                if (w_empty) w_status = ST_EMPTY;
            end
            MODE_ADVANCE: begin
                if (!r_cur_on) w_status = ST_NOCUR;
            end
            MODE_READ, MODE_EXTRACT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (!w_cur_ok) begin
                    w_status = ST_NOCUR;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    assign w_need_word = (w_status == ST_OK) &&
                         ((r_mode == MODE_POP) || (r_mode == MODE_READ) ||
                          (r_mode == MODE_EXTRACT));

    assign o_sts.need_word  = w_need_word;
    assign o_sts.is_extract = (r_mode == MODE_EXTRACT);
    assign o_sts.more       = w_more;

    assign w_rpos  = i_ctl.sh_rd ? w_idx_nx : ((r_mode == MODE_POP) ? '0 : r_cur);
    assign w_re    = i_ctl.issue | i_ctl.sh_rd;
    assign w_raddr = f_phys(r_head, w_rpos);
    assign w_we    = i_ctl.sh_wr |
                     (i_ctl.fin && (r_mode == MODE_PUSH) && (w_status == ST_OK));
    assign w_waddr = f_phys(r_head, i_ctl.sh_wr ? r_idx : r_fill[PTR_W-1:0]);
    assign w_wdata = i_ctl.sh_wr ? w_rdata : r_data;

    fcx_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_head   = r_head;
        n_fill   = r_fill;
        n_cur    = r_cur;
        n_cur_on = r_cur_on;
        if (w_status == ST_OK) begin
            case (r_mode)
                MODE_PUSH: begin
                    n_fill = r_fill + CNT_W'(1);
                end
                MODE_POP: begin
                    n_head = f_phys(r_head, PTR_W'(1));
                    n_fill = r_fill - CNT_W'(1);
                    if (r_cur_on) begin
                        if (r_cur == '0) begin
                            n_cur_on = 1'b0;
                        end else begin
                            n_cur = r_cur - PTR_W'(1);
                        end
                    end
                end
                MODE_REWIND: begin
                    n_cur    = PTR_W'(r_fill - CNT_W'(1));
                    n_cur_on = 1'b1;
                end
                MODE_ADVANCE: begin
                    if (r_cur == '0) begin
                        n_cur_on = 1'b0;
                    end else begin
                        n_cur = r_cur - PTR_W'(1);
                    end
                end
                MODE_EXTRACT: begin
                    n_fill = r_fill - CNT_W'(1);
                    if (r_cur == '0) begin
                        n_cur_on = 1'b0;
                    end else begin
                        n_cur = r_cur - PTR_W'(1);
                    end
                end
                default: begin
                    n_fill = r_fill;
                end
            endcase
        end else if (r_mode == MODE_REWIND) begin
            n_cur    = '0;
            n_cur_on = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_fill   <= '0;
            r_cur    <= '0;
            r_cur_on <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= i_ctl.fin;
            if (i_ctl.fin) begin
                r_head   <= n_head;
                r_fill   <= n_fill;
                r_cur    <= n_cur;
                r_cur_on <= n_cur_on;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_mode <= i_cmd.mode;
            r_data <= DATA_WIDTH'(i_cmd.data);
        end
        if (i_ctl.issue) begin
            r_idx <= r_cur;
        end else if (i_ctl.sh_wr) begin
            r_idx <= w_idx_nx;
        end
        if (i_ctl.load) begin
            r_word <= w_rdata;
        end
        if (i_ctl.fin) begin
            r_rsp.word         <= w_need_word ? WORD_W'(r_word) : '0;
            r_rsp.word_valid   <= w_need_word;
            r_rsp.status       <= w_status;
            r_rsp.count        <= COUNT_W'(n_fill);
            r_rsp.cursor_valid <= n_cur_on;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_on |-> (CNT_W'(r_cur) < r_fill))
        else $error("cursor rests beyond the newest entry");

    a_fill_only_at_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.fin |=> $stable(r_fill))
        else $error("fill count changed outside the finishing step");

    a_shift_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.sh_wr |=> (r_idx == PTR_W'($past(r_idx) + PTR_W'(1))))
        else $error("shift index did not advance by one entry");

endmodule

>>> src/fifo_with_cursor_extract.sv
`timescale 1ns / 1ps
// Top level of the bounded word queue with a cursor and extraction.
//
// Channel   Direction  Handshake                Payload
// command   in         start high, busy low     i_cmd  (mode, data)
// result    out        o_done strobe, 1 cycle   o_rsp  (word, word_valid, status,
//                                                       count, cursor_valid)
//
// Push, rewind, advance, refused and unused commands go from accept through the issue
// and finish steps; pop and read add a load step because of the registered RAM read.
// Extract adds a load step, then a shift read and write for each entry newer than the
// cursor, since each is moved one slot through the single RAM read and write port.
// The result strobe comes in the cycle after the finishing step and cannot be stalled.
// Reset is synchronous and needs no clearing pass; the store is a circular buffer.
module fifo_with_cursor_extract #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  fcx_pkg::t_cmd i_cmd,
    output logic          busy,
    output logic          o_done,
    output fcx_pkg::t_rsp o_rsp
);
    import fcx_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;

    fcx_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_busy  (busy),
        .o_cmd   (w_ctl)
    );

    fcx_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

endmodule

>>> sim/fifo_with_cursor_extract_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the word queue with a cursor: directed cases, then random traffic.
module fifo_with_cursor_extract_tb;

    import fcx_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_cmd i_cmd;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    t_cmd              pending_cmds[$];
    t_rsp              awaited_rsps[$];
    logic [WORD_W-1:0] held_words[$];
    int                cursor_idx;
    bit                cursor_live;
    int                idle_pct;
    int                n_issued;
    int                n_accepted;
    int                n_errors;

    fifo_with_cursor_extract #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (WORD_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_rsp queue_step(t_cmd c);
        t_rsp r;
        r = '0;
        r.status = ST_OK;
        case (c.mode)
            MODE_PUSH: begin
                if (held_words.size() >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    held_words.push_back(c.data);
                end
            end
            MODE_POP: begin
                if (held_words.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.word = held_words.pop_front();
                    r.word_valid = 1'b1;
                    if (cursor_live) begin
                        if (cursor_idx == 0) begin
                            cursor_live = 1'b0;
                        end else begin
                            cursor_idx--;
                        end
                    end
                end
            end
            MODE_REWIND: begin
                if (held_words.size() == 0) begin
                    r.status = ST_EMPTY;
                    cursor_live = 1'b0;
                    cursor_idx = 0;
                end else begin
                    cursor_idx = held_words.size() - 1;
                    cursor_live = 1'b1;
                end
            end
            MODE_ADVANCE: begin
                if (!cursor_live) begin
                    r.status = ST_NOCUR;
                end else if (cursor_idx == 0) begin
                    cursor_live = 1'b0;
                end else begin
                    cursor_idx--;
                end
            end
            MODE_READ, MODE_EXTRACT: begin
                if (held_words.size() == 0) begin
                    r.status = ST_EMPTY;
                end else if (!cursor_live || cursor_idx >= held_words.size()) begin
                    r.status = ST_NOCUR;
                end else begin
                    r.word = held_words[cursor_idx];
                    r.word_valid = 1'b1;
                    if (c.mode == MODE_EXTRACT) begin
                        held_words.delete(cursor_idx);
                        if (cursor_idx == 0) begin
                            cursor_live = 1'b0;
                        end else begin
                            cursor_idx--;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        r.count = COUNT_W'(held_words.size());
        r.cursor_valid = cursor_live;
        return r;
    endfunction

    task automatic queue_cmd(logic [MODE_W-1:0] mode, logic [WORD_W-1:0] data);
        t_cmd c;
        c.mode = mode;
        c.data = data;
        pending_cmds.push_back(c);
    endtask

    function automatic t_cmd random_cmd(int push_pct);
        t_cmd c;
        int   pick;
        int   data_kind;
        data_kind = $urandom_range(0, 9);
        if (data_kind == 0) begin
            c.data = '0;
        end else if (data_kind == 1) begin
            c.data = '1;
        end else begin
            c.data = $urandom;
        end
        if ($urandom_range(0, 99) < push_pct) begin
            c.mode = MODE_PUSH;
        end else begin
            pick = $urandom_range(0, 19);
            if (pick < 4) begin
                c.mode = MODE_POP;
            end else if (pick < 7) begin
                c.mode = MODE_REWIND;
            end else if (pick < 11) begin
                c.mode = MODE_ADVANCE;
            end else if (pick < 14) begin
                c.mode = MODE_READ;
            end else if (pick < 19) begin
                c.mode = MODE_EXTRACT;
            end else begin
                c.mode = $urandom_range(0, 1) ? MODE_SPARE_B : MODE_SPARE_A;
            end
        end
        return c;
    endfunction

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!(start && n_issued != n_accepted)) begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    i_cmd <= pending_cmds.pop_front();
                    start <= 1'b1;
                    n_issued <= n_issued + 1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (o_done) begin
                if (awaited_rsps.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %p", $time, o_rsp);
                    n_errors++;
                end else begin
                    want = awaited_rsps.pop_front();
                    if (o_rsp.word !== want.word) begin
                        $display("%0t ns: word expected %h actual %h",
                                 $time, want.word, o_rsp.word);
                        n_errors++;
                    end
                    if (o_rsp.word_valid !== want.word_valid) begin
                        $display("%0t ns: word_valid expected %b actual %b",
                                 $time, want.word_valid, o_rsp.word_valid);
                        n_errors++;
                    end
                    if (o_rsp.status !== want.status) begin
                        $display("%0t ns: status expected %0d actual %0d",
                                 $time, want.status, o_rsp.status);
                        n_errors++;
                    end
                    if (o_rsp.count !== want.count) begin
                        $display("%0t ns: count expected %0d actual %0d",
                                 $time, want.count, o_rsp.count);
                        n_errors++;
                    end
                    if (o_rsp.cursor_valid !== want.cursor_valid) begin
                        $display("%0t ns: cursor_valid expected %b actual %b",
                                 $time, want.cursor_valid, o_rsp.cursor_valid);
                        n_errors++;
                    end
                end
            end
            if (start && !busy) begin
                awaited_rsps.push_back(queue_step(i_cmd));
                n_accepted <= n_accepted + 1;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int phase_idle[4];
        int push_pct;
        phase_idle = '{0, 71, 0, 16};
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        idle_pct = 0;
        n_issued = 0;
        n_accepted = 0;
        n_errors = 0;
        cursor_idx = 0;
        cursor_live = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_cmd(MODE_POP, '0);
        queue_cmd(MODE_READ, '0);
        queue_cmd(MODE_EXTRACT, '0);
        queue_cmd(MODE_REWIND, '0);
        queue_cmd(MODE_ADVANCE, '0);
        queue_cmd(MODE_PUSH, 32'h0000_0000);
        queue_cmd(MODE_PUSH, 32'hffff_ffff);
        queue_cmd(MODE_READ, '0);
        queue_cmd(MODE_EXTRACT, '0);
        queue_cmd(MODE_REWIND, '0);
        queue_cmd(MODE_READ, '0);
        queue_cmd(MODE_ADVANCE, '0);
        queue_cmd(MODE_ADVANCE, '0);
        queue_cmd(MODE_ADVANCE, '0);
        queue_cmd(MODE_SPARE_A, 32'h1234_5678);
        queue_cmd(MODE_SPARE_B, 32'hffff_ffff);
        queue_cmd(MODE_PUSH, 32'h5a5a_5a5a);
        queue_cmd(MODE_REWIND, '0);
        queue_cmd(MODE_ADVANCE, '0);
        queue_cmd(MODE_ADVANCE, '0);
        queue_cmd(MODE_POP, '0);
        queue_cmd(MODE_REWIND, '0);
        queue_cmd(MODE_EXTRACT, '0);
        queue_cmd(MODE_EXTRACT, '0);
        queue_cmd(MODE_PUSH, 32'ha5a5_a5a5);

        for (int phase = 0; phase < 4; phase++) begin
            while (pending_cmds.size() != 0 || start || awaited_rsps.size() != 0) begin
                @(posedge i_clk);
            end
            idle_pct = phase_idle[phase];
            for (int chunk = 0; chunk < 5; chunk++) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 20;
                    1: push_pct = 50;
                    default: push_pct = 90;
                endcase
                for (int n = 0; n < 35; n++) begin
                    pending_cmds.push_back(random_cmd(push_pct));
                end
            end
        end

        while (pending_cmds.size() != 0 || start || awaited_rsps.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (n_errors == 0 && awaited_rsps.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
